// ----- rtl/opq_pkg.sv -----
// Shared types and constants for the ordered-list priority queue.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package opq_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned OccWidth    = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_FRONT  = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] rtime;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic  load;
    logic  stream_ins;
    logic  ins_tail;
    logic  stream_scan;
    logic  shift_setup;
    logic  stream_shift;
    logic  shift_end;
    logic  set_res;
    stat_e res_code;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic done;
  } dp_status_t;

endpackage

// ----- rtl/opq_datapath.sv -----
// Datapath: entry memory, read stream, insert carry, minimum search and result registers.
// Depends on opq_pkg.
`timescale 1ns / 1ps

module opq_datapath #(
  parameter int unsigned CAPACITY = opq_pkg::DefCapacity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  opq_pkg::cmd_t       cmd_i,
  input  logic [1:0]          kind_i,
  input  logic [15:0]         proc_id_i,
  input  logic [7:0]          prio_i,
  input  logic [15:0]         run_time_i,
  output opq_pkg::dp_status_t sts_o,
  output logic [1:0]          status_o,
  output logic [15:0]         out_id_o,
  output logic [7:0]          out_prio_o,
  output logic [15:0]         out_time_o,
  output logic [4:0]          occupancy_o
);
  import opq_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  entry_t          mem_q [CAPACITY];
  entry_t          rdata_q;
  logic [IW-1:0]   ridx_q;
  logic            rv_q, rv_d;
  logic [CW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            placed_q, placed_d;
  kind_e           kind_q;
  entry_t          new_q;
  entry_t          carry_q;
  entry_t          min_q;
  logic [IW-1:0]   min_pos_q;
  stat_e           res_stat_q;
  entry_t          res_q;

  logic            streaming, ren;
  logic            place_now;
  logic            wen;
  logic [IW-1:0]   waddr;
  entry_t          wdata;

  assign streaming = cmd_i.stream_ins | cmd_i.stream_scan | cmd_i.stream_shift;
  assign ren       = streaming && (ptr_q < cnt_q);
  assign place_now = !placed_q && ((kind_q == KIND_FRONT) || (rdata_q.prio < new_q.prio));

  // Write port select
  always_comb begin
    wen   = 1'b0;
    waddr = ridx_q;
    wdata = carry_q;
    if (cmd_i.ins_tail) begin
      wen   = 1'b1;
      waddr = cnt_q[IW-1:0];
      wdata = placed_q ? carry_q : new_q;
    end else if (cmd_i.stream_ins && rv_q && (place_now || placed_q)) begin
      wen   = 1'b1;
      waddr = ridx_q;
      wdata = place_now ? new_q : carry_q;
    end else if (cmd_i.stream_shift && rv_q) begin
      wen   = 1'b1;
      waddr = ridx_q - IW'(1);
      wdata = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[waddr] <= wdata;
    end
    if (ren) begin
      rdata_q <= mem_q[ptr_q[IW-1:0]];
      ridx_q  <= ptr_q[IW-1:0];
    end
  end

  always_comb begin
    ptr_d    = ptr_q;
    rv_d     = ren;
    cnt_d    = cnt_q;
    placed_d = placed_q;
    if (ren) begin
      ptr_d = ptr_q + CW'(1);
    end
    if (cmd_i.load) begin
      ptr_d    = '0;
      rv_d     = 1'b0;
      placed_d = 1'b0;
    end
    if (cmd_i.stream_ins && rv_q && place_now) begin
      placed_d = 1'b1;
    end
    if (cmd_i.shift_setup) begin
      ptr_d = CW'(min_pos_q) + CW'(1);
    end
    if (cmd_i.ins_tail) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.shift_end) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      rv_q     <= 1'b0;
      cnt_q    <= '0;
      placed_q <= 1'b0;
    end else begin
      ptr_q    <= ptr_d;
      rv_q     <= rv_d;
      cnt_q    <= cnt_d;
      placed_q <= placed_d;
    end
  end

  // Item, carry, minimum and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q      <= kind_e'(kind_i);
      new_q.id    <= proc_id_i;
      new_q.prio  <= prio_i;
      new_q.rtime <= run_time_i;
    end
    if (cmd_i.stream_ins && rv_q && (place_now || placed_q)) begin
      carry_q <= rdata_q;
    end
    if (cmd_i.stream_scan && rv_q && ((ridx_q == '0) || (rdata_q.prio < min_q.prio))) begin
      min_q     <= rdata_q;
      min_pos_q <= ridx_q;
    end
    if (cmd_i.shift_setup) begin
      res_stat_q <= STAT_OK;
      res_q      <= min_q;
    end else if (cmd_i.set_res) begin
      res_stat_q <= cmd_i.res_code;
      res_q      <= '0;
    end
  end

  assign sts_o.full  = (cnt_q == CW'(CAPACITY));
  assign sts_o.empty = (cnt_q == '0);
  assign sts_o.done  = (ptr_q == cnt_q) && !rv_q;

  assign status_o    = res_stat_q;
  assign out_id_o    = res_q.id;
  assign out_prio_o  = res_q.prio;
  assign out_time_o  = res_q.rtime;
  assign occupancy_o = OccWidth'(cnt_q);

endmodule

// ----- rtl/opq_ctrl.sv -----
// Controller state machine: sequences insert, scan and shift passes over the entry memory.
// Depends on opq_pkg.
`timescale 1ns / 1ps

module opq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          kind_i,
  input  opq_pkg::dp_status_t sts_i,
  output opq_pkg::cmd_t       cmd_o,
  output logic                busy_o,
  output logic                done_o
);
  import opq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_code = STAT_OK;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          case (kind_e'(kind_i))
            KIND_INSERT, KIND_FRONT: begin
              if (sts_i.full) begin
                cmd_o.set_res  = 1'b1;
                cmd_o.res_code = STAT_FULL;
                state_d        = S_RESP;
              end else begin
                state_d = S_INSERT;
              end
            end
            KIND_REMOVE: begin
              if (sts_i.empty) begin
                cmd_o.set_res  = 1'b1;
                cmd_o.res_code = STAT_EMPTY;
                state_d        = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              cmd_o.set_res = 1'b1;
              state_d       = S_RESP;
            end
          endcase
        end
      end
      S_INSERT: begin
        cmd_o.stream_ins = 1'b1;
        if (sts_i.done) begin
          cmd_o.ins_tail = 1'b1;
          cmd_o.set_res  = 1'b1;
          state_d        = S_RESP;
        end
      end
      S_SCAN: begin
        cmd_o.stream_scan = 1'b1;
        if (sts_i.done) begin
          cmd_o.shift_setup = 1'b1;
          state_d           = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.stream_shift = 1'b1;
        if (sts_i.done) begin
          cmd_o.shift_end = 1'b1;
          state_d         = S_RESP;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

endmodule

// ----- rtl/ordered_list_priority_queue.sv -----
// Ordered-list priority queue, top level: controller plus datapath.
// Full, empty or unused kind answer straight from idle; insert walks the list once (no walk when empty);
// remove walks the list to find the smallest, then walks the entries behind it to close the gap.
// Throughput: one transaction at a time; start is taken only while busy_o is low; one entry/cycle.
// Reset: asynchronous active low; the list comes up empty, memory contents are not cleared.
// The result is shown for exactly one cycle on done_o; the receiver cannot stall it.
`timescale 1ns / 1ps

module ordered_list_priority_queue #(
  parameter int unsigned CAPACITY = opq_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] proc_id_i,
  input  logic [7:0]  prio_i,
  input  logic [15:0] run_time_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] out_id_o,
  output logic [7:0]  out_prio_o,
  output logic [15:0] out_time_o,
  output logic [4:0]  occupancy_o
);
  import opq_pkg::*;

  // Command and status buses between sequencer and datapath
  cmd_t       cmd;
  dp_status_t sts;

  // Sequencer: decides per transaction which passes run. An ordered insert or a
  // push-front walks the list once, slipping the new entry in and carrying each
  // displaced entry one slot down. A remove walks once to find the earliest
  // smallest priority, then walks the tail to close the gap.
  opq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (kind_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Datapath: single-port-write, registered-read entry memory, plus the
  // result registers that hold the answer through the strobe cycle.
  opq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .kind_i      (kind_i),
    .proc_id_i   (proc_id_i),
    .prio_i      (prio_i),
    .run_time_i  (run_time_i),
    .sts_o       (sts),
    .status_o    (status_o),
    .out_id_o    (out_id_o),
    .out_prio_o  (out_prio_o),
    .out_time_o  (out_time_o),
    .occupancy_o (occupancy_o)
  );

endmodule

// ----- rtl/opq_checker.sv -----
// Port-level checker for the ordered-list priority queue, bound to the top level.
// Depends on opq_pkg.
`timescale 1ns / 1ps

module opq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [15:0] out_id_o,
  input logic [7:0]  out_prio_o,
  input logic [15:0] out_time_o,
  input logic [4:0]  occupancy_o
);
  import opq_pkg::*;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe while idle");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STAT_OK)) |->
      ((out_id_o == '0) && (out_prio_o == '0) && (out_time_o == '0)))
    else $error("failed transaction reported nonzero entry fields");

  a_idle_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && !start_i) |=> $stable(occupancy_o))
    else $error("occupancy moved while idle");

endmodule

bind ordered_list_priority_queue opq_checker u_opq_checker (.*);

// ----- bench/tb.sv -----
// Self-checking bench for the ordered-list priority queue (ordered insert, push-front,
// remove-smallest). Depends on opq_pkg and the ordered_list_priority_queue RTL only.
`timescale 1ns / 1ps

module tb;
  import opq_pkg::*;

  localparam int unsigned Cap        = DefCapacity;
  localparam int unsigned TailCycles = 3 * Cap + 20;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxGap     = 40;

  // One expected transaction outcome, laid out like the result ports
  typedef struct packed {
    stat_e       status;
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] rtime;
    logic [4:0]  occ;
  } outcome_t;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        start_i    = 1'b0;
  logic [1:0]  kind_i     = KIND_NONE;
  logic [15:0] proc_id_i  = '0;
  logic [7:0]  prio_i     = '0;
  logic [15:0] run_time_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  status_o;
  logic [15:0] out_id_o;
  logic [7:0]  out_prio_o;
  logic [15:0] out_time_o;
  logic [4:0]  occupancy_o;

  // Shadow copy of the list, kept in step with every accepted transaction
  entry_t      shadow_list[Cap];
  int unsigned shadow_cnt = 0;

  outcome_t    pending_q[$];
  int unsigned mismatch_cnt    = 0;
  int unsigned cycle_cnt       = 0;
  int unsigned sender_idle_pct = 0;

  ordered_list_priority_queue #(
    .CAPACITY(Cap)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .kind_i     (kind_i),
    .proc_id_i  (proc_id_i),
    .prio_i     (prio_i),
    .run_time_i (run_time_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .out_id_o   (out_id_o),
    .out_prio_o (out_prio_o),
    .out_time_o (out_time_o),
    .occupancy_o(occupancy_o)
  );

  always #6 clk_i = ~clk_i;

  // Apply one transaction to the shadow list and return what the block must answer.
  // Inserts go before the first entry of strictly lower priority value, so equal
  // values keep arrival order; removes take the earliest-listed smallest value.
  function automatic outcome_t apply_to_list(kind_e k, entry_t e);
    outcome_t    r;
    int unsigned pos;
    int unsigned i;
    r = '0;
    r.status = STAT_OK;
    case (k)
      KIND_INSERT, KIND_FRONT: begin
        if (shadow_cnt >= Cap) begin
          r.status = STAT_FULL;
        end else begin
          pos = 0;
          if (k == KIND_INSERT) begin
            while (pos < shadow_cnt && shadow_list[pos].prio >= e.prio) pos++;
          end
          for (i = shadow_cnt; i > pos; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[pos] = e;
          shadow_cnt++;
        end
      end
      KIND_REMOVE: begin
        if (shadow_cnt == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          pos = 0;
          for (i = 1; i < shadow_cnt; i++) begin
            if (shadow_list[i].prio < shadow_list[pos].prio) pos = i;
          end
          r.id    = shadow_list[pos].id;
          r.prio  = shadow_list[pos].prio;
          r.rtime = shadow_list[pos].rtime;
          for (i = pos; i + 1 < shadow_cnt; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_cnt--;
        end
      end
      default: ;  // unused kind: no change, plain OK answer
    endcase
    r.occ = shadow_cnt[4:0];
    return r;
  endfunction

  // Mostly random words, with the all-zero and all-one extremes now and then
  function automatic logic [15:0] pick_word();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  // Narrow values most of the time so equal priorities meet often
  function automatic logic [7:0] pick_prio();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) return 8'($urandom_range(7));
    if (r < 6) return 8'($urandom_range(255, 248));
    return 8'($urandom_range(255));
  endfunction

  // Drive one transaction, hold it until the block takes it, record the expected
  // answer, then idle for a random stretch. Start stays high when no idle follows,
  // so back-to-back transactions never lower and raise it in one time step.
  task automatic send_cmd(kind_e k, logic [15:0] id, logic [7:0] pr, logic [15:0] tm);
    entry_t      e;
    int unsigned gap;
    start_i    <= 1'b1;
    kind_i     <= k;
    proc_id_i  <= id;
    prio_i     <= pr;
    run_time_i <= tm;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    e.id    = id;
    e.prio  = pr;
    e.rtime = tm;
    pending_q.push_back(apply_to_list(k, e));
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and hold off until every outstanding answer has come back
  task automatic wait_drained();
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Extremes of every field, every kind, ties on both insert and remove, and the
  // empty-list remove on both ends
  task automatic test_corner_cases();
    send_cmd(KIND_REMOVE, 16'h1234, 8'h55, 16'h4321);
    send_cmd(KIND_NONE,   16'hFFFF, 8'hFF, 16'hFFFF);
    send_cmd(KIND_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_cmd(KIND_INSERT, 16'h0000, 8'h00, 16'h0000);
    send_cmd(KIND_INSERT, 16'h0001, 8'd5,  16'hAAAA);
    send_cmd(KIND_INSERT, 16'h0002, 8'd5,  16'h5555);
    send_cmd(KIND_FRONT,  16'h0003, 8'd200, 16'h00FF);
    send_cmd(KIND_FRONT,  16'h0004, 8'h00, 16'hFF00);
    send_cmd(KIND_NONE,   16'hBEEF, 8'h01, 16'hCAFE);
    repeat (6) send_cmd(KIND_REMOVE, 16'h0000, 8'h00, 16'h0000);
    send_cmd(KIND_REMOVE, 16'hFFFF, 8'hFF, 16'hFFFF);
  endtask

  // Fill the list to capacity, knock on it with both insert kinds, then empty it
  task automatic test_fill_drain();
    while (shadow_cnt < Cap) begin
      send_cmd(($urandom_range(3) == 0) ? KIND_FRONT : KIND_INSERT,
               pick_word(), pick_prio(), pick_word());
    end
    send_cmd(KIND_INSERT, pick_word(), pick_prio(), pick_word());
    send_cmd(KIND_FRONT,  pick_word(), pick_prio(), pick_word());
    while (shadow_cnt != 0) send_cmd(KIND_REMOVE, pick_word(), pick_prio(), pick_word());
    send_cmd(KIND_REMOVE, pick_word(), pick_prio(), pick_word());
  endtask

  // Bursts that lean toward growing, shrinking or holding the list steady
  task automatic test_random_mix(int unsigned n_items);
    int unsigned sent;
    int unsigned burst_len;
    int unsigned lean;
    int unsigned r;
    int unsigned ins_lim;
    int unsigned front_lim;
    int unsigned rem_lim;
    kind_e       k;
    sent = 0;
    while (sent < n_items) begin
      burst_len = $urandom_range(24, 4);
      lean      = $urandom_range(2);
      case (lean)
        0:       begin ins_lim = 55; front_lim = 75; rem_lim = 95; end
        1:       begin ins_lim = 25; front_lim = 35; rem_lim = 95; end
        default: begin ins_lim = 35; front_lim = 50; rem_lim = 93; end
      endcase
      repeat (burst_len) begin
        if (sent < n_items) begin
          r = $urandom_range(99);
          if (r < ins_lim)        k = KIND_INSERT;
          else if (r < front_lim) k = KIND_FRONT;
          else if (r < rem_lim)   k = KIND_REMOVE;
          else                    k = KIND_NONE;
          send_cmd(k, pick_word(), pick_prio(), pick_word());
          sent++;
        end
      end
    end
  endtask

  // Compare one result field and report any difference
  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // Take each result on the cycle its strobe is high and match it to the oldest
  // outstanding transaction
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual status %0h id %0h",
                 $time, status_o, out_id_o);
        mismatch_cnt++;
      end else begin
        want = pending_q.pop_front();
        check_field("status",    16'(want.status), 16'(status_o));
        check_field("out_id",    want.id,          out_id_o);
        check_field("out_prio",  16'(want.prio),   16'(out_prio_o));
        check_field("out_time",  want.rtime,       out_time_o);
        check_field("occupancy", 16'(want.occ),    16'(occupancy_o));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Release reset once, then run the three idle profiles on the sender side,
  // draining all outstanding answers between tests
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 16;
    test_corner_cases();
    wait_drained();
    test_fill_drain();
    wait_drained();
    test_random_mix(245);
    wait_drained();

    sender_idle_pct = 70;
    test_fill_drain();
    wait_drained();
    test_random_mix(245);
    wait_drained();

    sender_idle_pct = 0;
    test_fill_drain();
    wait_drained();
    test_random_mix(245);
    wait_drained();

    // Catch any stray result that trails the last expected one
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
